// ===== hw/rtl/c39_pkg.sv =====
// Shared types, constants and lookup functions for the Code 39 raster encoder.
// No dependencies; imported by every module of the block.
package c39_pkg;

  localparam int unsigned SymCount  = 44;
  localparam int unsigned ElemCount = 10;
  localparam int unsigned PrefixLen = 5;
  localparam int unsigned SuffixLen = 6;

  localparam logic [7:0] ByteBar    = 8'hFF;
  localparam logic [7:0] ByteSpace  = 8'h00;
  localparam logic [7:0] LaserBar   = 8'h7C;  // '|'
  localparam logic [7:0] LaserSpace = 8'h20;  // ' '
  localparam logic [7:0] ChEsc      = 8'd27;

  localparam logic [2:0] DotNarrow   = 3'd2;
  localparam logic [2:0] DotWide     = 3'd5;
  localparam logic [2:0] LaserNarrow = 3'd2;
  localparam logic [2:0] LaserWide   = 3'd4;
  localparam logic [2:0] EscRun      = 3'd1;

  localparam logic [5:0] StartStopIdx = 6'd0;

  typedef enum logic {
    MODE_DOT   = 1'b0,
    MODE_LASER = 1'b1
  } mode_e;

  typedef enum logic [2:0] {
    SEG_IDLE,
    SEG_PREFIX,
    SEG_START,
    SEG_CHAR,
    SEG_STOP,
    SEG_SUFFIX
  } seg_e;

  typedef struct packed {
    logic [7:0] char_code;
    logic       first_char;
    logic       last_char;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic [2:0]  repeat_count;
    logic [15:0] graphics_bytes;
    logic        run_last;
    logic        message_end;
  } out_item_t;

  typedef struct packed {
    logic       ok;
    logic [5:0] idx;
  } sym_t;

  // one classified character as queued between front and back
  typedef struct packed {
    logic       first;
    logic       last;
    logic       sym_ok;
    logic [5:0] sym_idx;
  } cmd_t;

  // element widths, MSB is element 0 (first bar); 1 = wide
  localparam logic [ElemCount-1:0] SymPat [SymCount] = '{
    10'b0100101000, 10'b0001101000, 10'b1001000010, 10'b0011000010,
    10'b1011000000, 10'b0001100010, 10'b1001100000, 10'b0011100000,
    10'b0001001010, 10'b1001001000, 10'b0011001000, 10'b1000010010,
    10'b0010010010, 10'b1010010000, 10'b0000110010, 10'b1000110000,
    10'b0010110000, 10'b0000011010, 10'b1000011000, 10'b0010011000,
    10'b0000111000, 10'b1000000110, 10'b0010000110, 10'b1010000100,
    10'b0000100110, 10'b1000100100, 10'b0010100100, 10'b0000001110,
    10'b1000001100, 10'b0010001100, 10'b0000101100, 10'b1100000010,
    10'b0110000010, 10'b1110000000, 10'b0100100010, 10'b1100100000,
    10'b0110100000, 10'b0100001010, 10'b1100001000, 10'b0110001000,
    10'b0101010000, 10'b0101000100, 10'b0100010100, 10'b0001010100
  };

  function automatic sym_t sym_lookup(input logic [7:0] ch);
    sym_t s;
    s.ok  = 1'b1;
    s.idx = '0;
    if (ch >= 8'h30 && ch <= 8'h39) begin
      s.idx = 6'(ch - 8'h30) + 6'd1;
    end else if (ch >= 8'h41 && ch <= 8'h5A) begin
      s.idx = 6'(ch - 8'h41) + 6'd11;
    end else begin
      case (ch)
        8'h2A:   s.idx = 6'd0;   // '*'
        8'h2D:   s.idx = 6'd37;  // '-'
        8'h2E:   s.idx = 6'd38;  // '.'
        8'h20:   s.idx = 6'd39;  // ' '
        8'h24:   s.idx = 6'd40;  // '$'
        8'h2F:   s.idx = 6'd41;  // '/'
        8'h2B:   s.idx = 6'd42;  // '+'
        8'h25:   s.idx = 6'd43;  // '%'
        default: s.ok  = 1'b0;
      endcase
    end
    return s;
  endfunction

  // laser spacing prefix: ESC & k 1 H
  function automatic logic [7:0] prefix_byte(input logic [2:0] i);
    logic [7:0] b;
    unique case (i)
      3'd0:    b = ChEsc;
      3'd1:    b = 8'h26;
      3'd2:    b = 8'h6B;
      3'd3:    b = 8'h31;
      3'd4:    b = 8'h48;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // laser spacing suffix: ESC & k 1 0 H
  function automatic logic [7:0] suffix_byte(input logic [2:0] i);
    logic [7:0] b;
    unique case (i)
      3'd0:    b = ChEsc;
      3'd1:    b = 8'h26;
      3'd2:    b = 8'h6B;
      3'd3:    b = 8'h31;
      3'd4:    b = 8'h30;
      3'd5:    b = 8'h48;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// ===== hw/rtl/code39_printer_raster_encoder.sv =====
// Code 39 barcode raster encoder.
// Input channel (in_valid_i / in_stall_o / in_data_i) takes one message
// character per beat with first/last flags. Output channel (out_valid_o /
// out_stall_i / out_data_o) gives one run per beat: a byte and its repeat
// count, the running dot-matrix byte total, and end-of-character and
// end-of-message flags. A character gives 10 runs, plus 10 for the start
// symbol and 10 for the stop symbol when flagged, plus 5 prefix and 6 suffix
// runs in laser mode; unknown characters give nothing of their own.
// The back end emits one run per cycle unless the output stalls. From an
// idle block, an accepted character passes the queue, the back-end state
// and the output register before its first run leaves; consecutive
// characters follow with no gap. A two-entry queue lets the front take
// new characters while the back end is busy; in_stall_o rises only when
// it is full. A stalled output holds its beat and freezes the back end.
// Write printer_mode (cfg_we_i / cfg_wdata_i) only while idle.
// Reset clears the mode to dot-matrix, the byte total and message state;
// no beat is in flight afterwards.
module code39_printer_raster_encoder #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  c39_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output c39_pkg::out_item_t out_data_o
);
  import c39_pkg::*;

  mode_e mode_q, mode_d;
  logic  q_push, q_full, q_pop, q_valid;
  cmd_t  q_wdata, q_rdata;

  assign mode_d = cfg_we_i ? mode_e'(cfg_wdata_i) : mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_DOT;
    end else begin
      mode_q <= mode_d;
    end
  end

  c39_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_data_o   (q_wdata)
  );

  c39_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_wdata),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_data_o  (q_rdata)
  );

  c39_back #(
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mode_i      (mode_q),
    .q_valid_i   (q_valid),
    .q_data_i    (q_rdata),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

`ifndef NO_ASSERTIONS
  a_msg_end_is_run_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.message_end |-> out_data_o.run_last)
    else $error("message_end without run_last");

  a_repeat_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.repeat_count != 3'd0 && out_data_o.repeat_count <= 3'd5)
    else $error("repeat_count out of range");

  a_single_byte_escape : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.repeat_count == 3'd1 |-> mode_q == MODE_LASER)
    else $error("single-byte run outside laser mode");
`endif

endmodule

// ===== hw/rtl/c39_front.sv =====
// Front end: accepts message characters, classifies them against the Code 39
// symbol set and tracks message framing. Depends on c39_pkg.
module c39_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  c39_pkg::in_item_t in_data_i,
  input  logic             q_full_i,
  output logic             q_push_o,
  output c39_pkg::cmd_t    q_data_o
);
  import c39_pkg::*;

  logic in_message_q, in_message_d;
  logic accept;
  logic first_eff;
  sym_t sym;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  // a character outside a message opens one implicitly
  assign first_eff = in_data_i.first_char || !in_message_q;
  assign sym       = sym_lookup(in_data_i.char_code);

  assign q_data_o.first   = first_eff;
  assign q_data_o.last    = in_data_i.last_char;
  assign q_data_o.sym_ok  = sym.ok;
  assign q_data_o.sym_idx = sym.idx;

  // drop items that produce no runs
  assign q_push_o = accept && (first_eff || sym.ok || in_data_i.last_char);

  assign in_message_d = accept ? !in_data_i.last_char : in_message_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_message_q <= 1'b0;
    end else begin
      in_message_q <= in_message_d;
    end
  end

endmodule

// ===== hw/rtl/c39_fifo.sv =====
// Two-entry command queue between front and back end.
// Depends on c39_pkg for the command type.
module c39_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  c39_pkg::cmd_t push_data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output c39_pkg::cmd_t pop_data_o
);
  import c39_pkg::*;

  localparam int unsigned Depth = 2;

  cmd_t       mem_q [Depth];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign full_o     = cnt_q == 2'(Depth);
  assign valid_o    = cnt_q != 2'd0;
  assign pop_data_o = mem_q[rd_ptr_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = do_push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== hw/rtl/c39_back.sv =====
// Back end: walks the segments of one queued character (prefix, start, symbol,
// stop, suffix), one run per cycle while the output is not stalled, keeps the
// graphics byte total and drives the output register. Depends on c39_pkg.
module c39_back #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  c39_pkg::mode_e     mode_i,
  input  logic               q_valid_i,
  input  c39_pkg::cmd_t      q_data_i,
  output logic               q_pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output c39_pkg::out_item_t out_data_o
);
  import c39_pkg::*;

  seg_e       seg_q, seg_d;
  logic [3:0] elem_q, elem_d;
  cmd_t       cur_q, cur_d;

  logic [COUNT_BITS-1:0] cnt_q, cnt_d, cnt_after;
  logic [COUNT_BITS:0]   cnt_sum;

  logic      out_valid_q, out_valid_d;
  out_item_t out_q, out_d;

  logic       active, out_free, fire, seg_end, item_done, load;
  seg_e       seg_nxt;
  logic [3:0] seg_last;

  logic [7:0]           run_byte;
  logic [2:0]           run_cnt;
  logic                 run_gfx;
  logic [5:0]           sym_idx;
  logic [ElemCount-1:0] pat;
  logic                 wide, bar;
  logic [15:0]          gfx_view;

  function automatic seg_e first_seg(input cmd_t c, input mode_e m);
    seg_e s;
    if (c.first) begin
      s = (m == MODE_LASER) ? SEG_PREFIX : SEG_START;
    end else if (c.sym_ok) begin
      s = SEG_CHAR;
    end else begin
      s = SEG_STOP;
    end
    return s;
  endfunction

  function automatic seg_e next_seg(input seg_e s, input cmd_t c, input mode_e m);
    seg_e n;
    unique case (s)
      SEG_PREFIX: n = SEG_START;
      SEG_START:  n = c.sym_ok ? SEG_CHAR : (c.last ? SEG_STOP : SEG_IDLE);
      SEG_CHAR:   n = c.last ? SEG_STOP : SEG_IDLE;
      SEG_STOP:   n = (m == MODE_LASER) ? SEG_SUFFIX : SEG_IDLE;
      default:    n = SEG_IDLE;
    endcase
    return n;
  endfunction

  assign active    = seg_q != SEG_IDLE;
  assign out_free  = !out_valid_q || !out_stall_i;
  assign fire      = active && out_free;
  assign seg_nxt   = next_seg(seg_q, cur_q, mode_i);
  assign seg_end   = elem_q == seg_last;
  assign item_done = fire && seg_end && seg_nxt == SEG_IDLE;
  // chain the next command in the cycle of the last run: no bubble
  assign load      = q_valid_i && (!active || item_done);
  assign q_pop_o   = load;

  // next state
  always_comb begin
    seg_d  = seg_q;
    elem_d = elem_q;
    cur_d  = cur_q;
    if (load) begin
      cur_d  = q_data_i;
      seg_d  = first_seg(q_data_i, mode_i);
      elem_d = '0;
    end else if (fire) begin
      if (seg_end) begin
        seg_d  = seg_nxt;
        elem_d = '0;
      end else begin
        elem_d = elem_q + 4'd1;
      end
    end
  end

  // run outputs for the current element
  always_comb begin
    sym_idx  = (seg_q == SEG_CHAR) ? cur_q.sym_idx : StartStopIdx;
    pat      = SymPat[sym_idx];
    wide     = pat[4'(ElemCount - 1) - elem_q];
    bar      = !elem_q[0];
    run_byte = ByteSpace;
    run_cnt  = EscRun;
    run_gfx  = 1'b0;
    seg_last = 4'(ElemCount - 1);
    unique case (seg_q)
      SEG_PREFIX: begin
        run_byte = prefix_byte(elem_q[2:0]);
        seg_last = 4'(PrefixLen - 1);
      end
      SEG_SUFFIX: begin
        run_byte = suffix_byte(elem_q[2:0]);
        seg_last = 4'(SuffixLen - 1);
      end
      SEG_START, SEG_CHAR, SEG_STOP: begin
        if (mode_i == MODE_LASER) begin
          run_byte = bar ? LaserBar : LaserSpace;
          run_cnt  = wide ? LaserWide : LaserNarrow;
        end else begin
          run_byte = bar ? ByteBar : ByteSpace;
          run_cnt  = wide ? DotWide : DotNarrow;
          run_gfx  = 1'b1;
        end
      end
      default: begin
        run_byte = ByteSpace;
      end
    endcase
  end

  // saturating data byte total
  assign cnt_sum   = {1'b0, cnt_q} + (COUNT_BITS + 1)'(run_cnt);
  assign cnt_after = !run_gfx ? cnt_q :
                     (cnt_sum[COUNT_BITS] ? '1 : cnt_sum[COUNT_BITS-1:0]);

  generate
    if (COUNT_BITS >= 16) begin : g_view_trunc
      assign gfx_view = cnt_after[15:0];
    end else begin : g_view_ext
      assign gfx_view = {{(16 - COUNT_BITS){1'b0}}, cnt_after};
    end
  endgenerate

  always_comb begin
    cnt_d = cnt_q;
    if (fire) begin
      cnt_d = cnt_after;
    end
    // a new message clears the total before its first run
    if (load && q_data_i.first) begin
      cnt_d = '0;
    end
  end

  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (fire) begin
      out_valid_d          = 1'b1;
      out_d.out_byte       = run_byte;
      out_d.repeat_count   = run_cnt;
      out_d.graphics_bytes = gfx_view;
      out_d.run_last       = seg_end && seg_nxt == SEG_IDLE;
      out_d.message_end    = seg_end && seg_nxt == SEG_IDLE && cur_q.last;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_q       <= SEG_IDLE;
      elem_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      seg_q       <= seg_d;
      elem_q      <= elem_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
